@@ rtl/hsvr_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsvr_pkg
// Shared types and constants of the HSV to RGB converter: pixel payloads,
// algorithm codes, register map and pipeline control bundle.
// ----------------------------------------------------------------------------
package hsvr_pkg;

  localparam int NUM_STAGES = 4;

  localparam int CFG_AW = 3;
  localparam int CFG_DW = 32;

  localparam logic [0:0] CFG_IDX_MODE = 1'b0;

  localparam logic [1:0] MODE_GENERIC = 2'd0;
  localparam logic [1:0] MODE_RAINBOW = 2'd1;
  localparam logic [1:0] MODE_RAW     = 2'd2;

  localparam logic [7:0] GEN_SPAN       = 8'd43;
  localparam logic [7:0] RB_THIRD       = 8'(256 / 3);
  localparam logic [7:0] RB_TWO_THIRD   = 8'((256 * 2) / 3);
  localparam logic [7:0] RB_SECT_MASK   = 8'h1F;
  localparam logic [7:0] RAW_SECT_SPAN  = 8'h40;

  typedef struct packed {
    logic [7:0] hue;
    logic [7:0] saturation;
    logic [7:0] value;
  } hsv_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } rgb_t;

  typedef struct packed {
    logic [NUM_STAGES-1:0] en;
  } ctrl_t;

endpackage

@@ rtl/hsvr_cfg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsvr_cfg
// APB-style register block holding the conversion algorithm select.
// ----------------------------------------------------------------------------
module hsvr_cfg
  import hsvr_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [CFG_AW-1:0] cfg_paddr,
  input  logic [CFG_DW-1:0] cfg_pwdata,
  output logic [CFG_DW-1:0] cfg_prdata,
  output logic              cfg_pready,
  output logic [1:0]        mode
);

  logic [1:0] mode_r;
  logic [1:0] mode_nxt;
  logic       hit_mode;

  assign hit_mode   = (cfg_paddr[CFG_AW-1:2] == CFG_IDX_MODE);
  assign cfg_pready = 1'b1;

  always_comb begin
    mode_nxt = mode_r;
    if (cfg_psel && cfg_penable && cfg_pwrite && hit_mode) begin
      mode_nxt = cfg_pwdata[1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_GENERIC;
    end else begin
      mode_r <= mode_nxt;
    end
  end

  always_comb begin
    cfg_prdata = '0;
    if (hit_mode) begin
      cfg_prdata = {{(CFG_DW-2){1'b0}}, mode_r};
    end
  end

  assign mode = mode_r;

endmodule

@@ rtl/hsvr_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsvr_ctrl
// Pipeline flow control: per-stage valid bits and load enables that let
// bubbles collapse and hold the occupied stages ahead of a stalled output.
// ----------------------------------------------------------------------------
module hsvr_ctrl
  import hsvr_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_valid,
  output logic  in_ready,
  output logic  out_valid,
  input  logic  out_ready,
  output ctrl_t ctrl
);

  logic [NUM_STAGES-1:0] vld_r;
  logic [NUM_STAGES-1:0] vld_nxt;
  logic [NUM_STAGES-1:0] en;

  always_comb begin
    en[NUM_STAGES-1] = !vld_r[NUM_STAGES-1] || out_ready;
    for (int k = NUM_STAGES - 2; k >= 0; k--) begin
      en[k] = !vld_r[k] || en[k+1];
    end
  end

  always_comb begin
    vld_nxt = vld_r;
    if (en[0]) begin
      vld_nxt[0] = in_valid;
    end
    for (int k = 1; k < NUM_STAGES; k++) begin
      if (en[k]) begin
        vld_nxt[k] = vld_r[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  assign in_ready  = en[0];
  assign out_valid = vld_r[NUM_STAGES-1];
  assign ctrl.en   = en;

`ifndef NO_ASSERTIONS
  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> out_valid)
    else $error("Stalled result was dropped.");

  a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> vld_r[0])
    else $error("Accepted transfer did not enter the first stage.");

  a_full_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    ((&vld_r) && !out_ready) |-> !in_ready)
    else $error("Full stalled pipeline still accepts a transfer.");

  a_bubble_opens: assert property (@(posedge clk) disable iff (!rst_n)
    !(&vld_r) |-> in_ready)
    else $error("Pipeline with a free stage refuses a transfer.");
`endif

endmodule

@@ rtl/hsvr_dp.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsvr_dp
// Four-stage conversion datapath: section decode, first products, second
// products with channel selection, and the rainbow brightness curve.
// ----------------------------------------------------------------------------
module hsvr_dp
  import hsvr_pkg::*;
(
  input  logic       clk,
  input  ctrl_t      ctrl,
  input  logic [1:0] mode,
  input  hsv_t       in_data,
  output rgb_t       out_data
);

  function automatic logic [7:0] mul8(input logic [7:0] a, input logic [7:0] b);
    logic [15:0] prod;
    prod = 16'(a) * 16'(b);
    return prod[15:8];
  endfunction

  function automatic logic [7:0] rb_sat(input logic [7:0] x, input logic [7:0] s,
                                        input logic [7:0] fl);
    logic [7:0] y;
    if (s == 8'hFF) begin
      y = x;
    end else if (s == 8'h00) begin
      y = 8'hFF;
    end else begin
      y = (x != 8'h00) ? 8'(mul8(x, s) + 8'd1) : 8'h00;
      y = 8'(y + fl);
    end
    return y;
  endfunction

  function automatic logic [7:0] rb_val(input logic [7:0] x, input logic [7:0] v,
                                        input logic [7:0] vv);
    logic [7:0] y;
    if (v == 8'hFF) begin
      y = x;
    end else if (vv == 8'h00) begin
      y = 8'h00;
    end else if (x != 8'h00) begin
      y = 8'(mul8(x, vv) + 8'd1);
    end else begin
      y = x;
    end
    return y;
  endfunction

  // Stage 1: section decode and first constant products.
  logic [1:0] s1_mode_r;
  hsv_t       s1_hsv_r;
  logic [2:0] s1_region_r, s1_region_nxt;
  logic [7:0] s1_rem_r, s1_rem_nxt;
  rgb_t       s1_rb_r, s1_rb_nxt;
  logic [7:0] s1_fl_r, s1_fl_nxt;

  logic [7:0]  base;
  logic [7:0]  diff;
  logic [15:0] rem_prod;
  logic [7:0]  off8;
  logic [7:0]  third;
  logic [7:0]  twoth;

  always_comb begin
    priority if (in_data.hue >= 8'(GEN_SPAN * 5)) begin
      s1_region_nxt = 3'd5;
    end else if (in_data.hue >= 8'(GEN_SPAN * 4)) begin
      s1_region_nxt = 3'd4;
    end else if (in_data.hue >= 8'(GEN_SPAN * 3)) begin
      s1_region_nxt = 3'd3;
    end else if (in_data.hue >= 8'(GEN_SPAN * 2)) begin
      s1_region_nxt = 3'd2;
    end else if (in_data.hue >= GEN_SPAN) begin
      s1_region_nxt = 3'd1;
    end else begin
      s1_region_nxt = 3'd0;
    end
    base       = 8'(8'(s1_region_nxt) * GEN_SPAN);
    diff       = 8'(in_data.hue - base);
    rem_prod   = 16'(diff) * 16'd6;
    s1_rem_nxt = rem_prod[7:0];

    off8  = 8'((in_data.hue & RB_SECT_MASK) << 3);
    third = mul8(off8, RB_THIRD);
    twoth = mul8(off8, RB_TWO_THIRD);
    unique case (in_data.hue[7:5])
      3'd0: s1_rb_nxt = '{8'(8'd255 - third), third, 8'd0};
      3'd1: s1_rb_nxt = '{8'd171, 8'(8'd85 + third), 8'd0};
      3'd2: s1_rb_nxt = '{8'(8'd171 - twoth), 8'(8'd170 + third), 8'd0};
      3'd3: s1_rb_nxt = '{8'd0, 8'(8'd255 - third), third};
      3'd4: s1_rb_nxt = '{8'd0, 8'(8'd171 - twoth), 8'(8'd85 + twoth)};
      3'd5: s1_rb_nxt = '{third, 8'd0, 8'(8'd255 - third)};
      3'd6: s1_rb_nxt = '{8'(8'd85 + third), 8'd0, 8'(8'd171 - third)};
      default: s1_rb_nxt = '{8'(8'd170 + third), 8'd0, 8'(8'd85 - third)};
    endcase

    s1_fl_nxt = mul8(in_data.value, ~in_data.saturation);
  end

  always_ff @(posedge clk) begin
    if (ctrl.en[0]) begin
      s1_mode_r   <= mode;
      s1_hsv_r    <= in_data;
      s1_region_r <= s1_region_nxt;
      s1_rem_r    <= s1_rem_nxt;
      s1_rb_r     <= s1_rb_nxt;
      s1_fl_r     <= s1_fl_nxt;
    end
  end

  // Stage 2: products on saturation and value.
  logic [1:0] s2_mode_r;
  logic [7:0] s2_s_r, s2_v_r;
  logic [2:0] s2_region_r;
  logic [7:0] s2_p_r, s2_p_nxt;
  logic [7:0] s2_ga_r, s2_ga_nxt;
  logic [7:0] s2_gb_r, s2_gb_nxt;
  rgb_t       s2_rb_r;
  logic [7:0] s2_rfl_r, s2_rfl_nxt;
  logic [7:0] s2_vv_r, s2_vv_nxt;
  logic [7:0] s2_up_r, s2_up_nxt;
  logic [7:0] s2_dn_r, s2_dn_nxt;
  logic [7:0] s2_fl_r;
  logic [1:0] s2_sect_r;

  logic [7:0]  amp;
  logic [5:0]  off;
  logic [5:0]  off_dn;
  logic [13:0] up_prod;
  logic [13:0] dn_prod;

  always_comb begin
    s2_p_nxt   = mul8(s1_hsv_r.value, ~s1_hsv_r.saturation);
    s2_ga_nxt  = mul8(s1_hsv_r.saturation, s1_rem_r);
    s2_gb_nxt  = mul8(s1_hsv_r.saturation, ~s1_rem_r);
    s2_rfl_nxt = mul8(~s1_hsv_r.saturation, ~s1_hsv_r.saturation);
    s2_vv_nxt  = mul8(s1_hsv_r.value, s1_hsv_r.value);
    amp        = 8'(s1_hsv_r.value - s1_fl_r);
    off        = 6'(s1_hsv_r.hue & (RAW_SECT_SPAN - 8'd1));
    off_dn     = ~off;
    up_prod    = 14'(off) * 14'(amp);
    dn_prod    = 14'(off_dn) * 14'(amp);
    s2_up_nxt  = 8'(up_prod[13:6] + s1_fl_r);
    s2_dn_nxt  = 8'(dn_prod[13:6] + s1_fl_r);
  end

  always_ff @(posedge clk) begin
    if (ctrl.en[1]) begin
      s2_mode_r   <= s1_mode_r;
      s2_s_r      <= s1_hsv_r.saturation;
      s2_v_r      <= s1_hsv_r.value;
      s2_region_r <= s1_region_r;
      s2_p_r      <= s2_p_nxt;
      s2_ga_r     <= s2_ga_nxt;
      s2_gb_r     <= s2_gb_nxt;
      s2_rb_r     <= s1_rb_r;
      s2_rfl_r    <= s2_rfl_nxt;
      s2_vv_r     <= s2_vv_nxt;
      s2_up_r     <= s2_up_nxt;
      s2_dn_r     <= s2_dn_nxt;
      s2_fl_r     <= s1_fl_r;
      s2_sect_r   <= s1_hsv_r.hue[7:6];
    end
  end

  // Stage 3: final generic products, rainbow saturation and channel select.
  logic [1:0] s3_mode_r;
  logic [7:0] s3_v_r;
  logic [7:0] s3_vv_r;
  rgb_t       s3_rgb_r, s3_rgb_nxt;

  logic [7:0] gq;
  logic [7:0] gt;
  rgb_t       gen_rgb;
  rgb_t       rb_rgb;
  rgb_t       raw_rgb;

  always_comb begin
    gq = mul8(s2_v_r, ~s2_ga_r);
    gt = mul8(s2_v_r, ~s2_gb_r);
    unique case (s2_region_r)
      3'd0: gen_rgb = '{s2_v_r, gt, s2_p_r};
      3'd1: gen_rgb = '{gq, s2_v_r, s2_p_r};
      3'd2: gen_rgb = '{s2_p_r, s2_v_r, gt};
      3'd3: gen_rgb = '{s2_p_r, gq, s2_v_r};
      3'd4: gen_rgb = '{gt, s2_p_r, s2_v_r};
      default: gen_rgb = '{s2_v_r, s2_p_r, gq};
    endcase
    if (s2_s_r == 8'h00) begin
      gen_rgb = '{s2_v_r, s2_v_r, s2_v_r};
    end

    rb_rgb.red   = rb_sat(s2_rb_r.red, s2_s_r, s2_rfl_r);
    rb_rgb.green = rb_sat(s2_rb_r.green, s2_s_r, s2_rfl_r);
    rb_rgb.blue  = rb_sat(s2_rb_r.blue, s2_s_r, s2_rfl_r);

    unique case (s2_sect_r)
      2'd0: raw_rgb = '{s2_dn_r, s2_up_r, s2_fl_r};
      2'd1: raw_rgb = '{s2_fl_r, s2_dn_r, s2_up_r};
      default: raw_rgb = '{s2_up_r, s2_fl_r, s2_dn_r};
    endcase

    unique case (s2_mode_r)
      MODE_RAINBOW: s3_rgb_nxt = rb_rgb;
      MODE_RAW:     s3_rgb_nxt = raw_rgb;
      default:      s3_rgb_nxt = gen_rgb;
    endcase
  end

  always_ff @(posedge clk) begin
    if (ctrl.en[2]) begin
      s3_mode_r <= s2_mode_r;
      s3_v_r    <= s2_v_r;
      s3_vv_r   <= s2_vv_r;
      s3_rgb_r  <= s3_rgb_nxt;
    end
  end

  // Stage 4: rainbow brightness curve into the output register.
  rgb_t s4_rgb_r, s4_rgb_nxt;

  always_comb begin
    s4_rgb_nxt = s3_rgb_r;
    if (s3_mode_r == MODE_RAINBOW) begin
      s4_rgb_nxt.red   = rb_val(s3_rgb_r.red, s3_v_r, s3_vv_r);
      s4_rgb_nxt.green = rb_val(s3_rgb_r.green, s3_v_r, s3_vv_r);
      s4_rgb_nxt.blue  = rb_val(s3_rgb_r.blue, s3_v_r, s3_vv_r);
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.en[3]) begin
      s4_rgb_r <= s4_rgb_nxt;
    end
  end

  assign out_data = s4_rgb_r;

endmodule

@@ rtl/hsv_to_rgb_multi_mode.sv @@
// A pixel moves through the stage 1, 2, 3 and 4 registers; stage 4 drives out_data.
// One pixel per cycle while out_ready is high; the four stages hold up to four pixels.
// A stall holds the run of occupied stages before the output; bubbles still collapse.
// Reset clears all stage valid bits and sets the algorithm select to generic.
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsv_to_rgb_multi_mode
// HSV to RGB pixel converter, 8 bits per channel, with a register-selected
// generic, rainbow or raw conversion algorithm.
// ----------------------------------------------------------------------------
module hsv_to_rgb_multi_mode
  import hsvr_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  hsv_t              in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output rgb_t              out_data,
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [CFG_AW-1:0] cfg_paddr,
  input  logic [CFG_DW-1:0] cfg_pwdata,
  output logic [CFG_DW-1:0] cfg_prdata,
  output logic              cfg_pready
);

  logic [1:0] mode;
  ctrl_t      ctrl;

  hsvr_cfg u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .mode        (mode)
  );

  hsvr_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .ctrl      (ctrl)
  );

  hsvr_dp u_dp (
    .clk      (clk),
    .ctrl     (ctrl),
    .mode     (mode),
    .in_data  (in_data),
    .out_data (out_data)
  );

endmodule
